FILE: sv/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the PLL factor search unit
// Field widths, search limits, status codes and the result record that
// the search core hands to the top level.
// ----------------------------------------------------------------------------
package pfs_pkg;

  // Field widths of the channels.
  localparam int TARGET_W   = 9;
  localparam int SOURCE_W   = 5;
  localparam int STATUS_W   = 3;
  localparam int MUL_CODE_W = 8;
  localparam int DIV_CODE_W = 4;
  localparam int PREDIV_W   = 3;

  // Search limits.
  localparam int MAX_MUL = 256;
  localparam int MAX_DIV = 16;

  // Counter widths: each counter must hold its limit plus one.
  localparam int MUL_W  = $clog2(MAX_MUL + 2);
  localparam int DIV_W  = $clog2(MAX_DIV + 2);
  localparam int VCO_W  = MUL_W + 1;
  localparam int PROD_W = TARGET_W + DIV_W;

  // Frequency limits in MHz.
  localparam int VCO_LIMIT = 200;
  localparam int OUT_LIMIT = 90;

  // Source clock range and reset value.
  localparam int SOURCE_MIN   = 2;
  localparam int SOURCE_MAX   = 16;
  localparam int SOURCE_RESET = 16;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FACTORS = 3'd1,
    ST_BAD_SOURCE = 3'd2,
    ST_VCO_HIGH   = 3'd3,
    ST_OUT_HIGH   = 3'd4
  } pfs_status_t;

  // One result beat.
  typedef struct packed {
    pfs_status_t                 status;
    logic [MUL_CODE_W-1:0]       mul_code;
    logic [DIV_CODE_W-1:0]       div_code;
    logic [PREDIV_W-1:0]         prediv_code;
  } pfs_result_t;

  // Handshake between the top level and the search core.
  typedef struct packed {
    logic start;
    logic take;
  } pfs_core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } pfs_core_stat_t;

endpackage

FILE: sv/pfs_channels.sv
// ----------------------------------------------------------------------------
// pfs_channels: valid/ready channels of the PLL factor search unit
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Request channel: one target frequency per beat.
interface pfs_in_if import pfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_mhz;

  modport source (output valid, output target_mhz, input ready);
  modport sink   (input valid, input target_mhz, output ready);
endinterface

// Result channel: status and factor codes per beat.
interface pfs_out_if import pfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [MUL_CODE_W-1:0] mul_code;
  logic [DIV_CODE_W-1:0] div_code;
  logic [PREDIV_W-1:0]   prediv_code;

  modport source (output valid, output status, output mul_code, output div_code,
                  output prediv_code, input ready);
  modport sink   (input valid, input status, input mul_code, input div_code,
                  input prediv_code, output ready);
endinterface

// Configuration channel: source clock frequency per beat.
interface pfs_cfg_if import pfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SOURCE_W-1:0] source_mhz;

  modport source (output valid, output source_mhz, input ready);
  modport sink   (input valid, input source_mhz, output ready);
endinterface

FILE: sv/pfs_search_core.sv
// ----------------------------------------------------------------------------
// pfs_search_core: sequencer and compare unit of the factor search
// Walks multiplier and divider one candidate per cycle. The candidate
// floor(2*mul/div) is compared with the target without a divider, by
// keeping target*div in a running register: the candidate matches when
// target*div <= 2*mul < target*div + div, and is above when 2*mul reaches
// the upper bound.
// ----------------------------------------------------------------------------
module pfs_search_core import pfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pfs_core_ctl_t       ctl,
  input  logic [TARGET_W-1:0] target_mhz,
  input  logic [SOURCE_W-1:0] source_mhz,
  output pfs_core_stat_t      stat,
  output pfs_result_t         result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;
  logic [MUL_W-1:0]    mul_r, mul_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [PROD_W-1:0]   lo_r, lo_nxt;
  pfs_result_t         res_r, res_nxt;

  logic [PROD_W-1:0]   hi;
  logic [PROD_W-1:0]   two_mul;
  logic [MUL_W-1:0]    mul_m1;
  logic [DIV_W-1:0]    div_m1;
  logic                bad_source;
  logic                exhausted;
  logic                match;
  logic                above;

  // Shared compare unit: bounds of the current candidate interval.
  assign two_mul   = PROD_W'({mul_r, 1'b0});
  assign hi        = lo_r + PROD_W'(div_r);
  assign match     = (two_mul >= lo_r) && (two_mul < hi);
  assign above     = (two_mul >= hi);
  assign exhausted = (mul_r > MUL_W'(MAX_MUL)) || (div_r > DIV_W'(MAX_DIV));
  assign mul_m1    = mul_r - MUL_W'(1);
  assign div_m1    = div_r - DIV_W'(1);

  // The source must be even and within range to give exactly 2 MHz.
  assign bad_source = (source_mhz < SOURCE_W'(SOURCE_MIN)) ||
                      (source_mhz > SOURCE_W'(SOURCE_MAX)) || source_mhz[0];

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    target_nxt = target_r;
    mul_nxt    = mul_r;
    div_nxt    = div_r;
    lo_nxt     = lo_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          target_nxt = target_mhz;
          mul_nxt    = MUL_W'(1);
          div_nxt    = DIV_W'(1);
          lo_nxt     = PROD_W'(target_mhz);
          if (bad_source) begin
            res_nxt.status      = ST_BAD_SOURCE;
            res_nxt.mul_code    = '0;
            res_nxt.div_code    = '0;
            res_nxt.prediv_code = '0;
            state_nxt           = S_DONE;
          end else begin
            res_nxt.prediv_code = PREDIV_W'(source_mhz[SOURCE_W-1:1] - 4'd1);
            state_nxt           = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (exhausted) begin
          res_nxt.status   = ST_NO_FACTORS;
          res_nxt.mul_code = '0;
          res_nxt.div_code = '0;
          state_nxt        = S_DONE;
        end else if (match) begin
          res_nxt.mul_code = mul_m1[MUL_CODE_W-1:0];
          res_nxt.div_code = div_m1[DIV_CODE_W-1:0];
          if (VCO_W'({mul_r, 1'b0}) > VCO_W'(VCO_LIMIT)) begin
            res_nxt.status = ST_VCO_HIGH;
          end else if (target_r > TARGET_W'(OUT_LIMIT)) begin
            // At a match the candidate output equals the target.
            res_nxt.status = ST_OUT_HIGH;
          end else begin
            res_nxt.status = ST_OK;
          end
          state_nxt = S_DONE;
        end else if (above) begin
          div_nxt = div_r + DIV_W'(1);
          lo_nxt  = lo_r + PROD_W'(target_r);
        end else begin
          mul_nxt = mul_r + MUL_W'(1);
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    target_r <= target_nxt;
    mul_r    <= mul_nxt;
    div_r    <= div_nxt;
    lo_r     <= lo_nxt;
    res_r    <= res_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign result    = res_r;

endmodule

FILE: sv/pll_factor_search_unit.sv
// ----------------------------------------------------------------------------
// pll_factor_search_unit: multiplier and divider search for a PLL
// Takes a target output frequency, returns status, N1, N2 and pre-divider
// codes for the configured source clock.
// ----------------------------------------------------------------------------
// One request beat yields one result beat. A request with a valid source
// starts the walk at the edge that accepts it and steps through the
// candidates until a match, or until the multiplier passes MAX_MUL or the
// divider passes MAX_DIV; the core then hands the result to the output
// register once that register is free. A bad source skips the walk. The
// walk runs on the single shared compare unit in the search core, and a new
// request is taken only once the core is idle. The output register lets
// the next request start while a result still waits. The source frequency
// register resets to 16 MHz and should be written only while no request is
// in flight.
// ----------------------------------------------------------------------------
module pll_factor_search_unit import pfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pfs_in_if.sink      in_ch,
  pfs_out_if.source   out_ch,
  pfs_cfg_if.sink     cfg_ch
);

  logic [SOURCE_W-1:0] source_r;
  logic                out_valid_r;
  pfs_result_t         out_data_r;
  pfs_core_ctl_t       core_ctl;
  pfs_core_stat_t      core_stat;
  pfs_result_t         core_res;
  logic                out_free;

  // Configuration register: always ready.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_r <= SOURCE_W'(SOURCE_RESET);
    end else if (cfg_ch.valid) begin
      source_r <= cfg_ch.source_mhz;
    end
  end

  // Request side: start the core on an accepted beat.
  assign in_ch.ready    = core_stat.idle;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign core_ctl.start = in_ch.valid && core_stat.idle;
  assign core_ctl.take  = core_stat.done && out_free;

  pfs_search_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (core_ctl),
    .target_mhz (in_ch.target_mhz),
    .source_mhz (source_r),
    .stat       (core_stat),
    .result     (core_res)
  );

  // Output register between the core and the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_ctl.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (core_ctl.take) begin
      out_data_r <= core_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_data_r.status;
  assign out_ch.mul_code    = out_data_r.mul_code;
  assign out_ch.div_code    = out_data_r.div_code;
  assign out_ch.prediv_code = out_data_r.prediv_code;

endmodule

FILE: sim/pfs_result_checker.sv
// ----------------------------------------------------------------------------
// pfs_result_checker: result checker for the PLL factor search unit
// Watches the request, result and configuration channels, predicts the
// status and factor codes of every accepted request and compares each
// result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pfs_result_checker import pfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pfs_in_if    in_mon,
  pfs_out_if   out_mon,
  pfs_cfg_if   cfg_mon,
  output int   mismatch_count,
  output int   results_pending
);

  // Local copy of the source frequency register.
  logic [SOURCE_W-1:0] source_copy;
  // Predicted results, oldest first.
  pfs_result_t         results_due[$];

  // Check the source, walk multiplier and divider from 1/1 exactly as the
  // block does, then apply the VCO and output limit checks.
  function automatic pfs_result_t predict_factors(input logic [TARGET_W-1:0] target,
                                                  input logic [SOURCE_W-1:0] src);
    pfs_result_t res;
    int unsigned mul_n;
    int unsigned div_n;
    int unsigned cand;
    bit          found;
    res        = '0;
    res.status = ST_OK;
    // A source that cannot be divided down to exactly 2 MHz wins over all.
    if (src < SOURCE_MIN || src > SOURCE_MAX || src[0]) begin
      res.status = ST_BAD_SOURCE;
      return res;
    end
    res.prediv_code = PREDIV_W'(src / 2 - 1);
    mul_n = 1;
    div_n = 1;
    found = 1'b0;
    while (!found && mul_n <= MAX_MUL && div_n <= MAX_DIV) begin
      cand = (2 * mul_n) / div_n;
      if (cand == target) begin
        found = 1'b1;
      end else if (cand > target) begin
        div_n++;
      end else begin
        mul_n++;
      end
    end
    if (!found) begin
      res.status = ST_NO_FACTORS;
      return res;
    end
    res.mul_code = MUL_CODE_W'(mul_n - 1);
    res.div_code = DIV_CODE_W'(div_n - 1);
    if (2 * mul_n > VCO_LIMIT) begin
      res.status = ST_VCO_HIGH;
    end else if ((2 * mul_n) / div_n > OUT_LIMIT) begin
      res.status = ST_OUT_HIGH;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Results are checked before new requests are queued, so a result beat
  // can never be matched against a request taken at the same edge.
  always @(posedge clk) begin
    pfs_result_t want;
    if (!rst_n) begin
      source_copy    = SOURCE_W'(SOURCE_RESET);
      mismatch_count = 0;
      results_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        source_copy = cfg_mon.source_mhz;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $error("result beat with no request pending: status %0d, mul_code %0d",
                 out_mon.status, out_mon.mul_code);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("mul_code", want.mul_code, out_mon.mul_code);
          check_field("div_code", want.div_code, out_mon.div_code);
          check_field("prediv_code", want.prediv_code, out_mon.prediv_code);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        results_due.push_back(predict_factors(in_mon.target_mhz, source_copy));
      end
    end
    results_pending = results_due.size();
  end

endmodule

FILE: sim/pll_factor_search_unit_tb.sv
// ----------------------------------------------------------------------------
// pll_factor_search_unit_tb: testbench top of the PLL factor search unit
// Drives target frequencies in bursts and source frequency writes between
// phases, stalls the result channel at random, and reports the verdict
// from the result checker beside the block.
// ----------------------------------------------------------------------------
module pll_factor_search_unit_tb import pfs_pkg::*; ();

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_pending;
  int   burst_left;
  int   idle_cycles;

  pfs_in_if  in_ch ();
  pfs_out_if out_ch ();
  pfs_cfg_if cfg_ch ();

  pll_factor_search_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pfs_result_checker factor_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Targets that hit zero, odd values, both limits, no match and all bits.
  logic [TARGET_W-1:0] corner_targets [16] = '{
    9'd0, 9'd1, 9'd2, 9'd3, 9'd90, 9'd91, 9'd92, 9'd100,
    9'd200, 9'd202, 9'd255, 9'd256, 9'd510, 9'd511, 9'd45, 9'd7
  };

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Send one target beat; the sender keeps valid high within a burst and
  // drops it for a random gap when the burst runs out.
  task automatic send_target(input logic [TARGET_W-1:0] target);
    in_ch.valid      = 1'b1;
    in_ch.target_mhz = target;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Hold off requests until every predicted result has come back.
  task automatic wait_for_results();
    in_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_source(input logic [SOURCE_W-1:0] src);
    wait_for_results();
    cfg_ch.valid      = 1'b1;
    cfg_ch.source_mhz = src;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Mostly small targets where the search finds factors, plus the full
  // range and the neighborhoods of the limits.
  function automatic logic [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return TARGET_W'($urandom_range(0, 100));
      5, 6, 7:       return TARGET_W'($urandom_range(0, 511));
      8:             return TARGET_W'($urandom_range(86, 104));
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return TARGET_W'($urandom_range(0, 4));
        end else begin
          return TARGET_W'($urandom_range(196, 511));
        end
      end
    endcase
  endfunction

  // Result receiver: ready runs and stalls of random length.
  initial begin
    int ready_left;
    out_ch.ready = 1'b0;
    ready_left   = 0;
    forever begin
      @(negedge clk);
      if (ready_left > 0) begin
        ready_left--;
      end else if (out_ch.ready) begin
        out_ch.ready = 1'b0;
        ready_left   = $urandom_range(0, 12);
      end else begin
        out_ch.ready = 1'b1;
        ready_left   = $urandom_range(0, 40);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pll_factor_search_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [SOURCE_W-1:0] src;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.target_mhz  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.source_mhz = '0;
    burst_left        = $urandom_range(0, 12);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset source of 16 MHz.
    foreach (corner_targets[i]) begin
      send_target(corner_targets[i]);
    end
    // Bad sources: out of range and odd.
    write_source(SOURCE_W'(31));
    send_target(9'd2);
    write_source(SOURCE_W'(0));
    send_target(9'd511);
    write_source(SOURCE_W'(7));
    send_target(9'd10);
    // Smallest valid source.
    write_source(SOURCE_W'(SOURCE_MIN));
    send_target(9'd0);
    send_target(9'd92);
    send_target(9'd511);

    // Random phases, each with a new source value.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        src = SOURCE_W'(SOURCE_MAX);
      end else if ($urandom_range(0, 3) == 0) begin
        src = SOURCE_W'($urandom_range(0, 31));
      end else begin
        src = SOURCE_W'(2 * $urandom_range(1, 8));
      end
      write_source(src);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 39) == 0) begin
          wait_for_results();
        end
        send_target(pick_target());
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("pll_factor_search_unit verification clean");
    end else begin
      $display("pll_factor_search_unit verification failed");
    end
    $finish;
  end

endmodule
